// ===== design/distance_vector_route_update_macros.svh =====
// ----------------------------------------------------------------------------
// Route update assertion macros
// Shared concurrent assertion forms used by the route update checker.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DVRU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("route update check failed");

// The consequent must hold in the cycle after the antecedent.
`define DVRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("route update check failed");

`endif

// ===== design/dvru_pkg.sv =====
// ----------------------------------------------------------------------------
// Route update package
// Table sizing, result codes, register map and controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

package dvru_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_OWN_ID = 1'b0;

    typedef enum logic [1:0] {
        ST_UNCHANGED = 2'd0,
        ST_IMPROVED  = 2'd1,
        ST_ADDED     = 2'd2,
        ST_DROPPED   = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic cmp;
        logic sel;
        logic upd;
    } t_cmd;

    function automatic logic [7:0] sat_inc(input logic [7:0] cost);
        sat_inc = (cost == 8'hFF) ? 8'hFF : cost + 8'd1;
    endfunction

    // Low four bits of a slot number, whatever the table depth.
    function automatic logic [3:0] to_index(input logic [IDX_W-1:0] slot);
        logic [IDX_W+3:0] wide;
        wide = (IDX_W + 4)'(slot);
        to_index = wide[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/dvru_if.sv =====
// ----------------------------------------------------------------------------
// Route update channels
// Valid/ready channels for advertised entries and update results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dvru_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_id;
    logic [7:0] dest_id;
    logic [7:0] adv_cost;

    modport source (output valid, source_id, dest_id, adv_cost, input ready);
    modport sink   (input valid, source_id, dest_id, adv_cost, output ready);
endinterface

interface dvru_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] entry_index;
    logic [7:0] entry_cost;
    logic [7:0] entry_next_hop;

    modport source (output valid, status, entry_index, entry_cost, entry_next_hop,
                    input ready);
    modport sink   (input valid, status, entry_index, entry_cost, entry_next_hop,
                    output ready);
endinterface

`default_nettype wire

// ===== design/dvru_ctrl.sv =====
// ----------------------------------------------------------------------------
// Route update controller
// Sequences compare, select and update for one beat, and owns result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output dvru_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_SEL  = 4'b0100,
        S_UPD  = 4'b1000
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic           r_out_valid;
    logic           n_out_valid;
    dvru_pkg::t_cmd cmd;

    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                cmd.cmp = 1'b1;
                n_state = S_SEL;
            end
            S_SEL: begin
                cmd.sel = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                // The table is only touched once the result register can take the beat.
                if (!r_out_valid || i_out_ready) begin
                    cmd.upd = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.upd) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

// ===== design/dvru_dpath.sv =====
// ----------------------------------------------------------------------------
// Route update datapath
// Route table, per-slot compare lanes, lowest-match select and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dvru_pkg::t_cmd    i_cmd,
    input  logic              i_seed,
    input  logic [7:0]        i_seed_id,
    input  logic [7:0]        i_source_id,
    input  logic [7:0]        i_dest_id,
    input  logic [7:0]        i_adv_cost,
    output logic [1:0]        o_status,
    output logic [3:0]        o_entry_index,
    output logic [7:0]        o_entry_cost,
    output logic [7:0]        o_entry_next_hop
);

    localparam int DEPTH = dvru_pkg::TABLE_DEPTH;
    localparam int IDX_W = dvru_pkg::IDX_W;
    localparam int CNT_W = dvru_pkg::CNT_W;

    // Route table
    logic [7:0]       r_dest [DEPTH];
    logic [7:0]       r_hop  [DEPTH];
    logic [7:0]       r_cost [DEPTH];
    logic [CNT_W-1:0] r_count;

    // Item being worked on
    logic [7:0]       r_src;
    logic [7:0]       r_dst;
    logic [7:0]       r_new_cost;
    logic [DEPTH-1:0] r_match;
    logic             r_found;
    logic [IDX_W-1:0] r_slot;
    logic [7:0]       r_cur_cost;
    logic [7:0]       r_cur_hop;

    // Result register
    dvru_pkg::t_status r_res_status;
    logic [3:0]        r_res_index;
    logic [7:0]        r_res_cost;
    logic [7:0]        r_res_hop;

    logic [DEPTH-1:0] low_match;
    logic [IDX_W-1:0] sel_slot;
    logic [7:0]       sel_cost;
    logic [7:0]       sel_hop;
    logic             improve;
    logic             add;
    logic             wr_en;
    logic [IDX_W-1:0] wr_slot;
    logic [7:0]       seed_val;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_src      <= i_source_id;
            r_dst      <= i_dest_id;
            r_new_cost <= dvru_pkg::sat_inc(i_adv_cost);
        end
    end

    // One compare lane per slot; slots at or above the fill count never match.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_match[i] <= (r_dest[i] == r_dst) && (CNT_W'(i) < r_count);
            end
        end
    end

    // Isolate the lowest set match bit, then encode it and read that slot by AND-OR.
    always_comb begin
        low_match = r_match & (~r_match + DEPTH'(1));
        sel_slot  = '0;
        sel_cost  = '0;
        sel_hop   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_slot = sel_slot | ({IDX_W{low_match[i]}} & IDX_W'(i));
            sel_cost = sel_cost | ({8{low_match[i]}} & r_cost[i]);
            sel_hop  = sel_hop  | ({8{low_match[i]}} & r_hop[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sel) begin
            r_found    <= |r_match;
            r_slot     <= sel_slot;
            r_cur_cost <= sel_cost;
            r_cur_hop  <= sel_hop;
        end
    end

    assign improve  = r_found && (r_new_cost < r_cur_cost);
    assign add      = !r_found && (r_count != CNT_W'(DEPTH));
    assign wr_en    = i_cmd.upd && (improve || add);
    assign wr_slot  = r_found ? r_slot : r_count[IDX_W-1:0];
    assign seed_val = i_rst_n ? i_seed_id : 8'd0;

    // Slot 0 is seeded on reset and on an own-id write; the other slots start undefined.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_seed) begin
            r_dest[0] <= seed_val;
            r_hop[0]  <= seed_val;
            r_cost[0] <= 8'd0;
        end else if (wr_en) begin
            if (add) begin
                r_dest[wr_slot] <= r_dst;
            end
            r_cost[wr_slot] <= r_new_cost;
            r_hop[wr_slot]  <= r_src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_seed) begin
            r_count <= CNT_W'(1);
        end else if (i_cmd.upd && add) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            if (improve) begin
                r_res_status <= dvru_pkg::ST_IMPROVED;
                r_res_index  <= dvru_pkg::to_index(r_slot);
                r_res_cost   <= r_new_cost;
                r_res_hop    <= r_src;
            end else if (r_found) begin
                r_res_status <= dvru_pkg::ST_UNCHANGED;
                r_res_index  <= dvru_pkg::to_index(r_slot);
                r_res_cost   <= r_cur_cost;
                r_res_hop    <= r_cur_hop;
            end else if (add) begin
                r_res_status <= dvru_pkg::ST_ADDED;
                r_res_index  <= dvru_pkg::to_index(r_count[IDX_W-1:0]);
                r_res_cost   <= r_new_cost;
                r_res_hop    <= r_src;
            end else begin
                r_res_status <= dvru_pkg::ST_DROPPED;
                r_res_index  <= 4'd0;
                r_res_cost   <= 8'd0;
                r_res_hop    <= 8'd0;
            end
        end
    end

    assign o_status         = r_res_status;
    assign o_entry_index    = r_res_index;
    assign o_entry_cost     = r_res_cost;
    assign o_entry_next_hop = r_res_hop;

endmodule

`default_nettype wire

// ===== design/distance_vector_route_update.sv =====
// ----------------------------------------------------------------------------
// Distance-vector route update
// Route table that folds advertised entries in: improve, keep, append or drop.
//
//   Channel   Direction  Beat contents
//   i_adv     in         source_id, dest_id, adv_cost
//   o_res     out        status, entry_index, entry_cost, entry_next_hop
//   APB       in/out     own_id at byte address 0
//
// Each beat runs through accept, compare in every slot lane, pick the
// lowest matching slot and read it, then update the table and the result
// register. The update step waits while an earlier result is still held.
// Reset, and any write of own_id, leave slot 0 as the self entry with cost
// zero and a fill count of one; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dvru_in_if.sink                       i_adv,
    dvru_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dvru_pkg::ADDR_W-1:0]   paddr,
    input  logic [dvru_pkg::DATA_W-1:0]   pwdata,
    output logic [dvru_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [7:0]     r_own_id;
    logic           own_wr;
    dvru_pkg::t_cmd cmd;

    assign pready = 1'b1;
    assign own_wr = psel && penable && pwrite && (paddr[2] == dvru_pkg::REG_OWN_ID);
    assign prdata = (paddr[2] == dvru_pkg::REG_OWN_ID)
                  ? {(dvru_pkg::DATA_W - 8)'(0), r_own_id} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= 8'd0;
        end else if (own_wr) begin
            r_own_id <= pwdata[7:0];
        end
    end

    dvru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_adv.valid),
        .o_in_ready  (i_adv.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (cmd)
    );

    dvru_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_seed           (own_wr),
        .i_seed_id        (pwdata[7:0]),
        .i_source_id      (i_adv.source_id),
        .i_dest_id        (i_adv.dest_id),
        .i_adv_cost       (i_adv.adv_cost),
        .o_status         (o_res.status),
        .o_entry_index    (o_res.entry_index),
        .o_entry_cost     (o_res.entry_cost),
        .o_entry_next_hop (o_res.entry_next_hop)
    );

endmodule

`default_nettype wire

// ===== design/dvru_checker.sv =====
// ----------------------------------------------------------------------------
// Route update checker
// Port-level assertions on the route update block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "distance_vector_route_update_macros.svh"

module dvru_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic [3:0] i_entry_index,
    input logic [7:0] i_entry_cost,
    input logic [7:0] i_entry_next_hop
);

    // A held result keeps its contents until it is taken.
    `DVRU_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_entry_index) && $stable(i_entry_cost) && $stable(i_entry_next_hop))

    // One beat at a time: the block is busy in the cycle after an accept.
    `DVRU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A dropped entry reports an empty slot.
    `DVRU_ASSERT_SAME(a_drop_zero, i_clk, i_rst_n, i_out_valid && (i_status == dvru_pkg::ST_DROPPED), (i_entry_index == 4'd0) && (i_entry_cost == 8'd0) && (i_entry_next_hop == 8'd0))

    // A written cost is an advertised cost plus one, so never zero.
    `DVRU_ASSERT_SAME(a_written_cost, i_clk, i_rst_n, i_out_valid && ((i_status == dvru_pkg::ST_ADDED) || (i_status == dvru_pkg::ST_IMPROVED)), i_entry_cost != 8'd0)

endmodule

bind distance_vector_route_update dvru_checker u_dvru_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_adv.valid),
    .i_in_ready       (i_adv.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_status         (o_res.status),
    .i_entry_index    (o_res.entry_index),
    .i_entry_cost     (o_res.entry_cost),
    .i_entry_next_hop (o_res.entry_next_hop)
);

`default_nettype wire
